// File: rtl/n2a_pkg.sv
// ----------------------------------------------------------------------------
// n2a_pkg
// Shared types, codes and helpers for the number to ASCII digits unit.
// ----------------------------------------------------------------------------
package n2a_pkg;

	localparam int IN_VALUE_W = 32;
	localparam int CHAR_W     = 7;

	localparam logic [1:0] MODE_DEC = 2'd0;

	localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;
	localparam logic [3:0]        NIB_TEN      = 4'd10;

	typedef struct packed {
		logic [1:0]            mode;
		logic [IN_VALUE_W-1:0] value;
	} in_t;

	typedef struct packed {
		logic [CHAR_W-1:0] digit_char;
		logic              last;
	} out_t;

	typedef struct packed {
		logic load;
		logic dabble;
		logic shift;
		logic emit;
		logic last;
	} cmd_t;

	typedef struct packed {
		logic top_zero;
		logic out_free;
	} sts_t;

	function automatic logic [CHAR_W-1:0] to_ascii(input logic [3:0] nib, input logic upper);
		logic [CHAR_W-1:0] base;
		if (nib < NIB_TEN) begin
			return CHAR_ZERO + CHAR_W'(nib);
		end
		base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
		return base + CHAR_W'(nib - NIB_TEN);
	endfunction

endpackage

// File: rtl/number_to_ascii_digits_unit.sv
// ----------------------------------------------------------------------------
// number_to_ascii_digits_unit
// Converts one binary value to ASCII decimal or hex digits, MSB digit first.
// ----------------------------------------------------------------------------
//  channel  | signals                    | word
//  ---------+----------------------------+------------------------------
//  item     | item_valid, item_stall     | in_t  {mode, value}
//  digit    | digit_valid, digit_stall   | out_t {digit_char, last}
//
//  Decimal: a load, VALUE_BITS shift-add-3 steps (capped at 32), a skip of
//  leading zero digits that keeps at least one, then one digit per cycle
//  unless digit_stall holds the output. Hex skips the conversion steps.
//  The next word is taken once the last digit sits in the output register.
//  Reset clears the sequencer and output valid; digit_stall holds emission.
// ----------------------------------------------------------------------------
module number_to_ascii_digits_unit import n2a_pkg::*; #(
	parameter int VALUE_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_stall,
	input  in_t  item,
	output logic digit_valid,
	input  logic digit_stall,
	output out_t digit
);

	cmd_t cmd;
	sts_t sts;
	logic busy;

	assign item_stall = busy;

	n2a_ctrl #(
		.VALUE_BITS(VALUE_BITS)
	) u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (item_valid),
		.is_hex(item.mode != MODE_DEC),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy)
	);

	n2a_dp #(
		.VALUE_BITS(VALUE_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.cmd        (cmd),
		.sts        (sts),
		.digit_stall(digit_stall),
		.digit_valid(digit_valid),
		.digit      (digit)
	);

endmodule

// File: rtl/n2a_ctrl.sv
// ----------------------------------------------------------------------------
// n2a_ctrl
// Sequencer: load, binary to BCD steps (decimal only), leading zero skip, digit emit.
// ----------------------------------------------------------------------------
module n2a_ctrl import n2a_pkg::*; #(
	parameter int VALUE_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic is_hex,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy
);

	localparam int VB   = (VALUE_BITS < IN_VALUE_W) ? VALUE_BITS : IN_VALUE_W;
	localparam int NDIG = (VB * 30103) / 100000 + 1;
	localparam int HDIG = (VB + 3) / 4;
	localparam int CW   = $clog2(NDIG + 1);
	localparam int SW   = $clog2(VB);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_EMIT
	} state_t;

	state_t        state_q;
	logic [CW-1:0] cnt_q;
	logic [SW-1:0] step_q;

	always_comb begin
		cmd        = '0;
		cmd.last   = (cnt_q == CW'(1));
		unique case (state_q)
			ST_IDLE: cmd.load   = start;
			ST_CONV: cmd.dabble = 1'b1;
			ST_SKIP: cmd.shift  = sts.top_zero && (cnt_q > CW'(1));
			ST_EMIT: cmd.emit   = sts.out_free;
			default: cmd        = '0;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						step_q  <= '0;
						cnt_q   <= is_hex ? CW'(HDIG) : CW'(NDIG);
						state_q <= is_hex ? ST_SKIP : ST_CONV;
					end
				end
				ST_CONV: begin
					step_q <= step_q + SW'(1);
					if (step_q == SW'(VB - 1)) begin
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (cmd.shift) begin
						cnt_q <= cnt_q - CW'(1);
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (cmd.emit) begin
						cnt_q <= cnt_q - CW'(1);
						if (cmd.last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/n2a_dp.sv
// ----------------------------------------------------------------------------
// n2a_dp
// Datapath: shift-add-3 BCD converter, digit shifter and output register.
// ----------------------------------------------------------------------------
module n2a_dp import n2a_pkg::*; #(
	parameter int VALUE_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  in_t  item,
	input  cmd_t cmd,
	output sts_t sts,
	input  logic digit_stall,
	output logic digit_valid,
	output out_t digit
);

	localparam int VB   = (VALUE_BITS < IN_VALUE_W) ? VALUE_BITS : IN_VALUE_W;
	localparam int NDIG = (VB * 30103) / 100000 + 1;
	localparam int HDIG = (VB + 3) / 4;
	localparam int DW   = 4 * NDIG;
	localparam int HW   = 4 * HDIG;

	logic [VB-1:0] bin_q;
	logic [DW-1:0] dig_q;
	logic [DW-1:0] adj;
	logic [DW-1:0] hex_load;
	logic          upper_q;
	logic          valid_q;
	out_t          digit_q;
	logic [3:0]    top_nib;

	assign top_nib  = dig_q[DW-1 -: 4];
	assign hex_load = DW'(item.value[VB-1:0]) << (DW - HW);

	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			adj[4*i +: 4] = (dig_q[4*i +: 4] >= 4'd5) ? dig_q[4*i +: 4] + 4'd3
			                                            : dig_q[4*i +: 4];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q   <= item.value[VB-1:0];
			upper_q <= item.mode[1];
			dig_q   <= (item.mode != MODE_DEC) ? hex_load : '0;
		end else if (cmd.dabble) begin
			dig_q <= {adj[DW-2:0], bin_q[VB-1]};
			bin_q <= bin_q << 1;
		end else if (cmd.shift || cmd.emit) begin
			dig_q <= dig_q << 4;
		end
		if (cmd.emit) begin
			digit_q.digit_char <= to_ascii(top_nib, upper_q);
			digit_q.last       <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.emit) begin
			valid_q <= 1'b1;
		end else if (!digit_stall) begin
			valid_q <= 1'b0;
		end
	end

	assign sts.top_zero = (top_nib == 4'd0);
	assign sts.out_free = !valid_q || !digit_stall;
	assign digit_valid  = valid_q;
	assign digit        = digit_q;

endmodule

// File: rtl/n2a_chk.sv
// ----------------------------------------------------------------------------
// n2a_chk
// Port-level checks for the number to ASCII digits unit.
// ----------------------------------------------------------------------------
module n2a_chk import n2a_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_stall,
	input in_t  item,
	input logic digit_valid,
	input logic digit_stall,
	input out_t digit
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		digit_valid && digit_stall |=> digit_valid && $stable(digit))
		else $error("stalled digit word changed");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("word taken while previous conversion starts");

	a_busy_mid_number: assert property (@(posedge clk) disable iff (!arst_n)
		digit_valid && !digit.last |-> item_stall)
		else $error("input open before last digit");

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		digit_valid |-> (digit.digit_char >= 7'h30 && digit.digit_char <= 7'h39) ||
		                (digit.digit_char >= 7'h41 && digit.digit_char <= 7'h46) ||
		                (digit.digit_char >= 7'h61 && digit.digit_char <= 7'h66))
		else $error("digit outside ASCII digit set");

endmodule

bind number_to_ascii_digits_unit n2a_chk u_chk (.*);

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for number_to_ascii_digits_unit. A short table of
// directed words (zero, all ones, digit-count boundaries, every mode code)
// is followed by random words biased toward short values and power-of-ten
// and power-of-sixteen boundaries. Input idles, output stalls at random. Every
// digit is checked in order against table text or an in-bench model.
// ----------------------------------------------------------------------------
module tb_top;
	import n2a_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] MODE_HEX_LO  = 2'd1;
	localparam logic [1:0] MODE_HEX_UP  = 2'd2;
	localparam logic [1:0] MODE_HEX_ALT = 2'd3;

	localparam int RANDOM_WORDS   = 240;
	localparam int MAX_GAP        = 16;
	localparam int MAX_DIGITS     = 16;
	localparam int TAIL_CYCLES    = 96;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PRINT_CAP      = 40;

	typedef struct {
		in_t   word;
		string text;
	} row_t;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	in_t  item;
	logic digit_valid;
	logic digit_stall;
	out_t digit;

	out_t expected_digits[$];
	row_t rows[$];
	int   mismatch_cnt;
	int   quiet_cycles;
	bit   steady_in;
	bit   steady_out;

	number_to_ascii_digits_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.digit_valid (digit_valid),
		.digit_stall (digit_stall),
		.digit       (digit)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	task automatic report_mismatch(string what, int want, int got);
		mismatch_cnt++;
		if (mismatch_cnt <= PRINT_CAP) begin
			$display("mismatch at %0t: %s want 0x%0h got 0x%0h", $realtime, what, want, got);
		end
	endtask

	function automatic logic [CHAR_W-1:0] nibble_char(logic [3:0] nib, logic upper);
		if (nib < 4'd10) begin
			return CHAR_ZERO + CHAR_W'(nib);
		end
		return (upper ? CHAR_UPPER_A : CHAR_LOWER_A) + CHAR_W'(nib - 4'd10);
	endfunction

	// digits collected LSD first, queued MSD first
	function automatic void predict_digits(in_t w);
		logic [IN_VALUE_W-1:0] v;
		logic [CHAR_W-1:0]     chars[$];
		logic                  hex;
		logic                  upper;
		out_t                  d;
		v     = w.value;
		hex   = (w.mode != MODE_DEC);
		upper = w.mode[1];
		do begin
			if (hex) begin
				chars.push_front(nibble_char(v[3:0], upper));
				v = v >> 4;
			end else begin
				chars.push_front(CHAR_ZERO + CHAR_W'(v % 10));
				v = v / 10;
			end
		end while (v != 0 && chars.size() < MAX_DIGITS);
		foreach (chars[i]) begin
			d.digit_char = chars[i];
			d.last       = (i == chars.size() - 1);
			expected_digits.push_back(d);
		end
	endfunction

	function automatic void expect_text(string text);
		out_t d;
		for (int i = 0; i < text.len(); i++) begin
			d.digit_char = CHAR_W'(text[i]);
			d.last       = (i == text.len() - 1);
			expected_digits.push_back(d);
		end
	endfunction

	function automatic void add_row(logic [1:0] mode, logic [IN_VALUE_W-1:0] value, string text);
		row_t r;
		r.word.mode  = mode;
		r.word.value = value;
		r.text       = text;
		rows.push_back(r);
	endfunction

	function automatic logic [IN_VALUE_W-1:0] draw_value();
		int unsigned p10[10] = '{1, 10, 100, 1000, 10000, 100000, 1000000, 10000000,
			100000000, 1000000000};
		case ($urandom_range(0, 6))
			0: return $urandom_range(0, 15);
			1: return $urandom_range(0, 1000);
			2: return $urandom >> $urandom_range(0, 31);
			3: return p10[$urandom_range(0, 9)] - $urandom_range(0, 1);
			4: return (32'h1 << (4 * $urandom_range(0, 7))) - $urandom_range(0, 1);
			default: return $urandom;
		endcase
	endfunction

	task automatic send_word(in_t w, string text);
		int gap;
		if ($urandom_range(0, 31) == 0) steady_in = !steady_in;
		gap = steady_in ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			item_valid <= 1'b0;
			item       <= in_t'($urandom);
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= w;
		do @(posedge clk); while (item_stall);
		if (text.len() == 0) predict_digits(w);
		else expect_text(text);
	endtask

	initial begin
		in_t w;
		arst_n       = 1'b0;
		item_valid   = 1'b0;
		item         = '0;
		mismatch_cnt = 0;
		steady_in    = 1'b0;

		add_row(MODE_DEC,     32'd0,          "0");
		add_row(MODE_HEX_LO,  32'd0,          "0");
		add_row(MODE_HEX_UP,  32'd0,          "0");
		add_row(MODE_HEX_ALT, 32'd0,          "0");
		add_row(MODE_DEC,     32'hffff_ffff,  "4294967295");
		add_row(MODE_HEX_LO,  32'hffff_ffff,  "ffffffff");
		add_row(MODE_HEX_UP,  32'hffff_ffff,  "FFFFFFFF");
		add_row(MODE_HEX_ALT, 32'hffff_ffff,  "FFFFFFFF");
		add_row(MODE_DEC,     32'd9,          "9");
		add_row(MODE_DEC,     32'd10,         "10");
		add_row(MODE_DEC,     32'd999999999,  "999999999");
		add_row(MODE_DEC,     32'd1000000000, "1000000000");
		add_row(MODE_DEC,     32'h8000_0000,  "2147483648");
		add_row(MODE_HEX_LO,  32'hf,          "f");
		add_row(MODE_HEX_LO,  32'h10,         "10");
		add_row(MODE_HEX_LO,  32'habcd_ef01,  "abcdef01");
		add_row(MODE_HEX_UP,  32'habcd_ef01,  "ABCDEF01");
		add_row(MODE_HEX_ALT, 32'h2a,         "2A");
		add_row(MODE_HEX_LO,  32'h1234_5678,  "");
		add_row(MODE_DEC,     32'h5555_5555,  "");
		add_row(MODE_DEC,     32'haaaa_aaaa,  "");
		add_row(MODE_HEX_ALT, 32'h0c0f_fee0,  "");

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) send_word(rows[i].word, rows[i].text);
		repeat (RANDOM_WORDS) begin
			w.mode  = 2'($urandom_range(0, 3));
			w.value = draw_value();
			send_word(w, "");
		end
		item_valid <= 1'b0;

		while (expected_digits.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0) begin
			$display("PASS number_to_ascii_digits_unit");
		end else begin
			$display("FAIL number_to_ascii_digits_unit");
		end
		$finish;
	end

	initial begin
		int hold;
		digit_stall = 1'b0;
		steady_out  = 1'b0;
		forever begin
			if ($urandom_range(0, 31) == 0) steady_out = !steady_out;
			hold = steady_out ? 0 : $urandom_range(0, MAX_GAP);
			if (hold > 0) begin
				digit_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				digit_stall <= 1'b0;
			end
			do @(posedge clk); while (!(digit_valid && !digit_stall));
		end
	end

	always @(posedge clk) begin
		out_t want;
		if (arst_n && digit_valid && !digit_stall) begin
			if (expected_digits.size() == 0) begin
				report_mismatch("digit with nothing expected", 0, int'(digit.digit_char));
			end else begin
				want = expected_digits.pop_front();
				if (digit.digit_char !== want.digit_char)
					report_mismatch("digit_char", int'(want.digit_char),
						int'(digit.digit_char));
				if (digit.last !== want.last)
					report_mismatch("last", int'(want.last), int'(digit.last));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (digit_valid && !digit_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL number_to_ascii_digits_unit");
			$finish;
		end
	end

	initial quiet_cycles = 0;

endmodule

// File: files.f
rtl/n2a_pkg.sv
rtl/n2a_ctrl.sv
rtl/n2a_dp.sv
rtl/number_to_ascii_digits_unit.sv
rtl/n2a_chk.sv
tb/tb_top.sv
